### rtl/ofc_pkg.sv
// Shared types and constants for the object-follow controller.
`timescale 1ns / 1ps

package ofc_pkg;

  // Operating modes, encoded as reported on mode_now.
  typedef enum logic [2:0] {
    MODE_WAIT     = 3'd0,
    MODE_FOLLOW   = 3'd1,
    MODE_SEARCH_L = 3'd2,
    MODE_SEARCH_R = 3'd3,
    MODE_BACK     = 3'd4,
    MODE_SPIN     = 3'd5
  } mode_t;

  // Motor drive codes.
  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_BACK = 2'd2;

  // LED color codes.
  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_GREEN = 2'd1;
  localparam logic [1:0] LED_RED   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ESCAPE_DIST = 3'd0;
  localparam logic [2:0] CFG_START_DIST  = 3'd1;
  localparam logic [2:0] CFG_STOP_DIST   = 3'd2;
  localparam logic [2:0] CFG_FIRST_STEPS = 3'd3;
  localparam logic [2:0] CFG_SWEEP_STEPS = 3'd4;
  localparam logic [2:0] CFG_BACK_STEPS  = 3'd5;
  localparam logic [2:0] CFG_SPIN_STEPS  = 3'd6;

  localparam int DistW  = 9;
  localparam int StepW  = 10;
  localparam int CfgIdxW = 3;

  // Current configuration, seen by the step logic.
  typedef struct packed {
    logic [DistW-1:0] escape_distance;
    logic [DistW-1:0] start_follow_distance;
    logic [DistW-1:0] stop_follow_distance;
    logic [StepW-1:0] first_search_steps;
    logic [StepW-1:0] sweep_search_steps;
    logic [StepW-1:0] back_off_steps;
    logic [StepW-1:0] spin_steps;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0] left_drive;
    logic [1:0] right_drive;
    logic [1:0] led_color;
    logic [2:0] mode_now;
    logic       finished;
  } result_t;

endpackage

### rtl/ofc_cfg_regs.sv
// Configuration register file of the object-follow controller.
`timescale 1ns / 1ps

module ofc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [ofc_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [ofc_pkg::StepW-1:0]     wr_data,
  output ofc_pkg::cfg_t                 cfg
);

  // Write decode; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_distance       <= 9'd20;
      cfg.start_follow_distance <= 9'd80;
      cfg.stop_follow_distance  <= 9'd30;
      cfg.first_search_steps    <= 10'd50;
      cfg.sweep_search_steps    <= 10'd100;
      cfg.back_off_steps        <= 10'd150;
      cfg.spin_steps            <= 10'd100;
    end else if (wr_en) begin
      case (wr_index)
        ofc_pkg::CFG_ESCAPE_DIST: cfg.escape_distance       <= wr_data[ofc_pkg::DistW-1:0];
        ofc_pkg::CFG_START_DIST:  cfg.start_follow_distance <= wr_data[ofc_pkg::DistW-1:0];
        ofc_pkg::CFG_STOP_DIST:   cfg.stop_follow_distance  <= wr_data[ofc_pkg::DistW-1:0];
        ofc_pkg::CFG_FIRST_STEPS: cfg.first_search_steps    <= wr_data;
        ofc_pkg::CFG_SWEEP_STEPS: cfg.sweep_search_steps    <= wr_data;
        ofc_pkg::CFG_BACK_STEPS:  cfg.back_off_steps        <= wr_data;
        ofc_pkg::CFG_SPIN_STEPS:  cfg.spin_steps            <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/ofc_step.sv
// Controller state and the single-step transition logic.
`timescale 1ns / 1ps

module ofc_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic [ofc_pkg::DistW-1:0]  range_cm,
  input  ofc_pkg::cfg_t              cfg,
  output ofc_pkg::result_t           res
);

  ofc_pkg::mode_t              mode, mode_next;
  logic                        last_side_left, last_side_left_next;
  logic [ofc_pkg::StepW-1:0]   step_count, step_count_next;
  logic [1:0]                  held_left, held_left_next;
  logic [1:0]                  held_right, held_right_next;
  logic [1:0]                  held_led, held_led_next;
  logic                        sweeping, sweeping_next;
  logic                        fin;

  logic                        near_escape, seen, close_in, search_left, limit_hit;
  logic [ofc_pkg::StepW-1:0]   limit, step_inc;

  // Distance compares and search limit.
  assign near_escape = (range_cm <= cfg.escape_distance);
  assign seen        = (range_cm <= cfg.start_follow_distance);
  assign close_in    = (range_cm <= cfg.stop_follow_distance);
  assign search_left = (mode == ofc_pkg::MODE_SEARCH_L);
  assign limit       = sweeping ? cfg.sweep_search_steps : cfg.first_search_steps;
  assign limit_hit   = (step_count >= limit);
  assign step_inc    = step_count + 10'd1;

  // Next-state logic for one control step.
  always_comb begin
    mode_next           = mode;
    last_side_left_next = last_side_left;
    step_count_next     = step_count;
    held_left_next      = held_left;
    held_right_next     = held_right;
    held_led_next       = held_led;
    sweeping_next       = sweeping;
    fin                 = 1'b0;
    case (mode)
      ofc_pkg::MODE_BACK: begin
        if (step_count >= cfg.back_off_steps) begin
          held_left_next  = ofc_pkg::DRV_BACK;
          held_right_next = ofc_pkg::DRV_FWD;
          step_count_next = 10'd1;
          mode_next       = ofc_pkg::MODE_SPIN;
        end else begin
          step_count_next = step_inc;
        end
      end
      ofc_pkg::MODE_SPIN: begin
        if (step_count >= cfg.spin_steps) begin
          held_left_next      = ofc_pkg::DRV_STOP;
          held_right_next     = ofc_pkg::DRV_STOP;
          held_led_next       = ofc_pkg::LED_OFF;
          fin                 = 1'b1;
          mode_next           = ofc_pkg::MODE_WAIT;
          last_side_left_next = 1'b0;
          step_count_next     = '0;
          sweeping_next       = 1'b0;
        end else begin
          step_count_next = step_inc;
        end
      end
      ofc_pkg::MODE_FOLLOW: begin
        if (near_escape) begin
          held_led_next   = ofc_pkg::LED_RED;
          held_left_next  = ofc_pkg::DRV_BACK;
          held_right_next = ofc_pkg::DRV_BACK;
          step_count_next = 10'd1;
          mode_next       = ofc_pkg::MODE_BACK;
        end else if (seen) begin
          held_led_next   = ofc_pkg::LED_GREEN;
          held_left_next  = close_in ? ofc_pkg::DRV_STOP : ofc_pkg::DRV_FWD;
          held_right_next = close_in ? ofc_pkg::DRV_STOP : ofc_pkg::DRV_FWD;
        end else begin
          // Object lost: search toward the side it was last seen on.
          held_led_next   = ofc_pkg::LED_RED;
          held_left_next  = ofc_pkg::DRV_STOP;
          held_right_next = ofc_pkg::DRV_STOP;
          step_count_next = '0;
          sweeping_next   = 1'b0;
          mode_next       = last_side_left ? ofc_pkg::MODE_SEARCH_L : ofc_pkg::MODE_SEARCH_R;
        end
      end
      ofc_pkg::MODE_SEARCH_L, ofc_pkg::MODE_SEARCH_R: begin
        if (near_escape) begin
          held_led_next   = ofc_pkg::LED_RED;
          held_left_next  = ofc_pkg::DRV_BACK;
          held_right_next = ofc_pkg::DRV_BACK;
          step_count_next = 10'd1;
          mode_next       = ofc_pkg::MODE_BACK;
        end else if (seen) begin
          held_led_next       = ofc_pkg::LED_GREEN;
          held_left_next      = ofc_pkg::DRV_STOP;
          held_right_next     = ofc_pkg::DRV_STOP;
          last_side_left_next = search_left;
          mode_next           = ofc_pkg::MODE_FOLLOW;
        end else if (limit_hit) begin
          // Turn time used up: reverse and sweep the other way.
          held_left_next  = ofc_pkg::DRV_STOP;
          held_right_next = ofc_pkg::DRV_STOP;
          sweeping_next   = 1'b1;
          step_count_next = '0;
          mode_next       = search_left ? ofc_pkg::MODE_SEARCH_R : ofc_pkg::MODE_SEARCH_L;
        end else begin
          held_led_next   = ofc_pkg::LED_RED;
          held_left_next  = search_left ? ofc_pkg::DRV_BACK : ofc_pkg::DRV_FWD;
          held_right_next = search_left ? ofc_pkg::DRV_FWD : ofc_pkg::DRV_BACK;
          step_count_next = step_inc;
        end
      end
      default: begin
        // Wait mode, and any unreachable code behaves as wait.
        if (near_escape) begin
          held_led_next   = ofc_pkg::LED_RED;
          held_left_next  = ofc_pkg::DRV_BACK;
          held_right_next = ofc_pkg::DRV_BACK;
          step_count_next = 10'd1;
          mode_next       = ofc_pkg::MODE_BACK;
        end else if (seen) begin
          held_led_next = ofc_pkg::LED_GREEN;
          mode_next     = ofc_pkg::MODE_FOLLOW;
        end else begin
          mode_next = ofc_pkg::MODE_WAIT;
        end
      end
    endcase
  end

  // Result of the step being taken this cycle.
  always_comb begin
    res.left_drive  = held_left_next;
    res.right_drive = held_right_next;
    res.led_color   = held_led_next;
    res.mode_now    = mode_next;
    res.finished    = fin;
  end

  // State registers advance once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= ofc_pkg::MODE_WAIT;
      last_side_left <= 1'b0;
      step_count     <= '0;
      held_left      <= ofc_pkg::DRV_STOP;
      held_right     <= ofc_pkg::DRV_STOP;
      held_led       <= ofc_pkg::LED_OFF;
      sweeping       <= 1'b0;
    end else if (fire) begin
      mode           <= mode_next;
      last_side_left <= last_side_left_next;
      step_count     <= step_count_next;
      held_left      <= held_left_next;
      held_right     <= held_right_next;
      held_led       <= held_led_next;
      sweeping       <= sweeping_next;
    end
  end

  // A finished back-off always moves on to the spin.
  a_back_to_spin: assert property (@(posedge clk) disable iff (rst)
    fire && mode == ofc_pkg::MODE_BACK && step_count >= cfg.back_off_steps
    |=> mode == ofc_pkg::MODE_SPIN)
    else $error("back-off end did not enter spin");

  // Without a step, the mode holds.
  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(mode))
    else $error("mode changed without a step");

  // The finished pulse only comes out of spin and returns to wait.
  a_fin_from_spin: assert property (@(posedge clk) disable iff (rst)
    res.finished |-> mode == ofc_pkg::MODE_SPIN && res.mode_now == ofc_pkg::MODE_WAIT)
    else $error("finished outside the end of spin");

endmodule

### rtl/object_follow_controller.sv
// Top level of the object-follow controller: input register, step logic, result register.
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+----------------------------------------------
//  in       | in_valid / in_stall         | distance_cm
//  out      | out_valid / out_stall       | left_drive, right_drive, led_color, mode_now,
//           |                             | finished
//  cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One transaction per clock is sustained while the output is not stalled; a step waits in
// the input register and its result is registered into the result register as it advances.
// The step logic between the two registers sets the clock rate.
// Synchronous reset empties both registers and restores state and configuration defaults.
// A stalled result holds; the input register keeps filling until both stages are full.
`timescale 1ns / 1ps

module object_follow_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [8:0]                   distance_cm,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   left_drive,
  output logic [1:0]                   right_drive,
  output logic [1:0]                   led_color,
  output logic [2:0]                   mode_now,
  output logic                         finished,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ofc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ofc_pkg::StepW-1:0]    cfg_data
);

  ofc_pkg::cfg_t               cfg;
  ofc_pkg::result_t            res, res_q;
  logic                        s1_valid;
  logic [ofc_pkg::DistW-1:0]   s1_dist;
  logic                        advance, in_take;

  assign cfg_ready = 1'b1;

  ofc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Stage handshake: a step completes when the result register is free or draining.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take || advance) begin
      s1_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_dist <= distance_cm;
    end
  end

  ofc_step u_step (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .range_cm (s1_dist),
    .cfg      (cfg),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign left_drive  = res_q.left_drive;
  assign right_drive = res_q.right_drive;
  assign led_color   = res_q.led_color;
  assign mode_now    = res_q.mode_now;
  assign finished    = res_q.finished;

  // Both stages full and the output stalled: the input must be held off.
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("input accepted while both stages were full");

  // A step that completes always leaves a result behind.
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("completed step produced no result");

  // A finished pulse always reports wait mode with the LED off.
  a_fin_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> mode_now == ofc_pkg::MODE_WAIT && led_color == ofc_pkg::LED_OFF)
    else $error("finished reported outside wait");

endmodule

### dv/tb_object_follow_controller.sv
// Self-checking testbench for the object-follow controller.
`timescale 1ns / 1ps

module tb_object_follow_controller;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int CHUNK_ITEMS = 94;
  localparam int MAX_REPORTS = 10;
  localparam logic [ofc_pkg::CfgIdxW-1:0] CFG_UNUSED_IDX = 3'd7;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_TYPED,
    ROW_REG_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [ofc_pkg::DistW-1:0]   sample_cm;
    logic [ofc_pkg::CfgIdxW-1:0] reg_idx;
    logic [ofc_pkg::StepW-1:0]   reg_val;
    ofc_pkg::result_t            want;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [ofc_pkg::DistW-1:0]   distance_cm = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  left_drive;
  logic [1:0]                  right_drive;
  logic [1:0]                  led_color;
  logic [2:0]                  mode_now;
  logic                        finished;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [ofc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [ofc_pkg::StepW-1:0]   cfg_data = '0;

  object_follow_controller u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .distance_cm (distance_cm),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .led_color   (led_color),
    .mode_now    (mode_now),
    .finished    (finished),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Controller settings as the block should hold them.
  logic [ofc_pkg::DistW-1:0] escape_cm = 9'd20;
  logic [ofc_pkg::DistW-1:0] follow_start_cm = 9'd80;
  logic [ofc_pkg::DistW-1:0] follow_stop_cm = 9'd30;
  logic [ofc_pkg::StepW-1:0] first_turn_steps = 10'd50;
  logic [ofc_pkg::StepW-1:0] sweep_turn_steps = 10'd100;
  logic [ofc_pkg::StepW-1:0] back_off_len = 10'd150;
  logic [ofc_pkg::StepW-1:0] spin_len = 10'd100;

  // Controller state as the block should hold it.
  ofc_pkg::mode_t            ctl_mode = ofc_pkg::MODE_WAIT;
  logic                      seen_left = 1'b0;
  logic [ofc_pkg::StepW-1:0] step_cnt = '0;
  logic [1:0]                hold_left_drv = ofc_pkg::DRV_STOP;
  logic [1:0]                hold_right_drv = ofc_pkg::DRV_STOP;
  logic [1:0]                hold_led = ofc_pkg::LED_OFF;
  logic                      in_sweep = 1'b0;

  ofc_pkg::result_t due_commands[$];
  stim_row_t        directed_rows[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off_request = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned samples_sent = 0;
  int unsigned commands_checked = 0;
  int unsigned escapes_done = 0;
  int unsigned search_reversals = 0;
  int unsigned reg_writes = 0;
  int unsigned backpressure_cycles = 0;

  // Clock generation.
  initial begin
    forever #6 clk = ~clk;
  end

  // Works out the motor, LED and mode outputs of one control step.
  function automatic ofc_pkg::result_t step_controller(
      input logic [ofc_pkg::DistW-1:0] sample_cm);
    ofc_pkg::result_t          cmd;
    logic                      finish_now;
    logic                      turning_left;
    logic [ofc_pkg::StepW-1:0] turn_limit;
    finish_now = 1'b0;
    turning_left = (ctl_mode == ofc_pkg::MODE_SEARCH_L);
    turn_limit = in_sweep ? sweep_turn_steps : first_turn_steps;
    if (ctl_mode == ofc_pkg::MODE_BACK) begin
      if (step_cnt >= back_off_len) begin
        hold_left_drv = ofc_pkg::DRV_BACK;
        hold_right_drv = ofc_pkg::DRV_FWD;
        step_cnt = 10'd1;
        ctl_mode = ofc_pkg::MODE_SPIN;
      end else begin
        step_cnt = step_cnt + 10'd1;
      end
    end else if (ctl_mode == ofc_pkg::MODE_SPIN) begin
      if (step_cnt >= spin_len) begin
        hold_left_drv = ofc_pkg::DRV_STOP;
        hold_right_drv = ofc_pkg::DRV_STOP;
        hold_led = ofc_pkg::LED_OFF;
        finish_now = 1'b1;
        ctl_mode = ofc_pkg::MODE_WAIT;
        seen_left = 1'b0;
        step_cnt = '0;
        in_sweep = 1'b0;
        escapes_done++;
      end else begin
        step_cnt = step_cnt + 10'd1;
      end
    end else if (sample_cm <= escape_cm) begin
      // Escape wins over everything outside the escape modes.
      hold_led = ofc_pkg::LED_RED;
      hold_left_drv = ofc_pkg::DRV_BACK;
      hold_right_drv = ofc_pkg::DRV_BACK;
      step_cnt = 10'd1;
      ctl_mode = ofc_pkg::MODE_BACK;
    end else if (ctl_mode == ofc_pkg::MODE_FOLLOW) begin
      if (sample_cm <= follow_start_cm) begin
        hold_led = ofc_pkg::LED_GREEN;
        hold_left_drv = (sample_cm > follow_stop_cm) ? ofc_pkg::DRV_FWD : ofc_pkg::DRV_STOP;
        hold_right_drv = hold_left_drv;
      end else begin
        hold_led = ofc_pkg::LED_RED;
        hold_left_drv = ofc_pkg::DRV_STOP;
        hold_right_drv = ofc_pkg::DRV_STOP;
        step_cnt = '0;
        in_sweep = 1'b0;
        ctl_mode = seen_left ? ofc_pkg::MODE_SEARCH_L : ofc_pkg::MODE_SEARCH_R;
      end
    end else if (ctl_mode == ofc_pkg::MODE_SEARCH_L || ctl_mode == ofc_pkg::MODE_SEARCH_R) begin
      if (sample_cm <= follow_start_cm) begin
        hold_led = ofc_pkg::LED_GREEN;
        hold_left_drv = ofc_pkg::DRV_STOP;
        hold_right_drv = ofc_pkg::DRV_STOP;
        seen_left = turning_left;
        ctl_mode = ofc_pkg::MODE_FOLLOW;
      end else if (step_cnt >= turn_limit) begin
        // Turn timed out: reverse and use the sweep length from now on.
        hold_left_drv = ofc_pkg::DRV_STOP;
        hold_right_drv = ofc_pkg::DRV_STOP;
        in_sweep = 1'b1;
        step_cnt = '0;
        ctl_mode = turning_left ? ofc_pkg::MODE_SEARCH_R : ofc_pkg::MODE_SEARCH_L;
        search_reversals++;
      end else begin
        hold_led = ofc_pkg::LED_RED;
        hold_left_drv = turning_left ? ofc_pkg::DRV_BACK : ofc_pkg::DRV_FWD;
        hold_right_drv = turning_left ? ofc_pkg::DRV_FWD : ofc_pkg::DRV_BACK;
        step_cnt = step_cnt + 10'd1;
      end
    end else begin
      ctl_mode = ofc_pkg::MODE_WAIT;
      if (sample_cm <= follow_start_cm) begin
        hold_led = ofc_pkg::LED_GREEN;
        ctl_mode = ofc_pkg::MODE_FOLLOW;
      end
    end
    cmd.left_drive = hold_left_drv;
    cmd.right_drive = hold_right_drv;
    cmd.led_color = hold_led;
    cmd.mode_now = ctl_mode;
    cmd.finished = finish_now;
    return cmd;
  endfunction

  function automatic logic [ofc_pkg::DistW-1:0] clamp_cm(input int v);
    if (v < 0) return '0;
    if (v > 511) return 9'd511;
    return v[ofc_pkg::DistW-1:0];
  endfunction

  function automatic stim_row_t sample_row(input logic [ofc_pkg::DistW-1:0] sample_cm);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PREDICTED;
    r.sample_cm = sample_cm;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [ofc_pkg::DistW-1:0] sample_cm,
                                          input logic [1:0] l, input logic [1:0] rd,
                                          input logic [1:0] led, input ofc_pkg::mode_t m,
                                          input logic fin);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TYPED;
    r.sample_cm = sample_cm;
    r.want.left_drive = l;
    r.want.right_drive = rd;
    r.want.led_color = led;
    r.want.mode_now = m;
    r.want.finished = fin;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [ofc_pkg::CfgIdxW-1:0] idx,
                                        input logic [ofc_pkg::StepW-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Offers one distance sample, with random idle cycles ahead of it, and records the
  // expected command once the transaction is accepted.
  task automatic offer_distance(input logic [ofc_pkg::DistW-1:0] sample_cm, input bit use_typed,
                                input ofc_pkg::result_t typed_cmd);
    ofc_pkg::result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    distance_cm <= sample_cm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = step_controller(sample_cm);
    due_commands.push_back(use_typed ? typed_cmd : predicted);
    samples_sent++;
  endtask

  // Stops offering samples and waits until every expected command has come out.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (due_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write transaction; the shadow settings follow at the handshake.
  task automatic write_reg(input logic [ofc_pkg::CfgIdxW-1:0] idx,
                           input logic [ofc_pkg::StepW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ofc_pkg::CFG_ESCAPE_DIST: escape_cm = val[ofc_pkg::DistW-1:0];
      ofc_pkg::CFG_START_DIST:  follow_start_cm = val[ofc_pkg::DistW-1:0];
      ofc_pkg::CFG_STOP_DIST:   follow_stop_cm = val[ofc_pkg::DistW-1:0];
      ofc_pkg::CFG_FIRST_STEPS: first_turn_steps = val;
      ofc_pkg::CFG_SWEEP_STEPS: sweep_turn_steps = val;
      ofc_pkg::CFG_BACK_STEPS:  back_off_len = val;
      ofc_pkg::CFG_SPIN_STEPS:  spin_len = val;
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Programs a full set of registers; each flavor stresses a different corner.
  task automatic program_chunk(input int flavor);
    int unsigned esc;
    int unsigned start;
    case (flavor)
      0: begin
        esc = $urandom_range(5, 40);
        start = $urandom_range(esc + 20, esc + 150);
        write_reg(ofc_pkg::CFG_ESCAPE_DIST, 10'(esc));
        write_reg(ofc_pkg::CFG_START_DIST, 10'(start));
        write_reg(ofc_pkg::CFG_STOP_DIST, 10'($urandom_range(esc, start)));
        write_reg(ofc_pkg::CFG_FIRST_STEPS, 10'($urandom_range(0, 12)));
        write_reg(ofc_pkg::CFG_SWEEP_STEPS, 10'($urandom_range(1, 20)));
        write_reg(ofc_pkg::CFG_BACK_STEPS, 10'($urandom_range(0, 8)));
        write_reg(ofc_pkg::CFG_SPIN_STEPS, 10'($urandom_range(0, 8)));
      end
      1: begin
        start = $urandom_range(0, 511);
        write_reg(ofc_pkg::CFG_ESCAPE_DIST, 10'($urandom_range(0, start)));
        write_reg(ofc_pkg::CFG_START_DIST, 10'(start));
        write_reg(ofc_pkg::CFG_STOP_DIST, 10'($urandom_range(0, 511)));
        write_reg(ofc_pkg::CFG_FIRST_STEPS, 10'($urandom_range(1, 3)));
        write_reg(ofc_pkg::CFG_SWEEP_STEPS, 10'($urandom_range(1, 3)));
        write_reg(ofc_pkg::CFG_BACK_STEPS, 10'($urandom_range(1, 3)));
        write_reg(ofc_pkg::CFG_SPIN_STEPS, 10'($urandom_range(1, 3)));
      end
      2: begin
        // Lowest settings: everything is seen and every timer runs out at once.
        write_reg(ofc_pkg::CFG_ESCAPE_DIST, 10'd0);
        write_reg(ofc_pkg::CFG_START_DIST, 10'd511);
        write_reg(ofc_pkg::CFG_STOP_DIST, 10'd0);
        write_reg(ofc_pkg::CFG_FIRST_STEPS, 10'd0);
        write_reg(ofc_pkg::CFG_SWEEP_STEPS, 10'd0);
        write_reg(ofc_pkg::CFG_BACK_STEPS, 10'd0);
        write_reg(ofc_pkg::CFG_SPIN_STEPS, 10'd0);
      end
      3: begin
        // Highest settings, with a small escape distance so the robot still moves.
        write_reg(ofc_pkg::CFG_ESCAPE_DIST, 10'($urandom_range(0, 10)));
        write_reg(ofc_pkg::CFG_START_DIST, 10'd511);
        write_reg(ofc_pkg::CFG_STOP_DIST, 10'd511);
        write_reg(ofc_pkg::CFG_FIRST_STEPS, 10'd1023);
        write_reg(ofc_pkg::CFG_SWEEP_STEPS, 10'd1023);
        write_reg(ofc_pkg::CFG_BACK_STEPS, 10'd1023);
        write_reg(ofc_pkg::CFG_SPIN_STEPS, 10'd1023);
      end
      default: begin
        // Full random data, upper bit of the distance registers included; back-off and spin stay short.
        write_reg(ofc_pkg::CFG_ESCAPE_DIST, 10'($urandom_range(0, 1023)));
        write_reg(ofc_pkg::CFG_START_DIST, 10'($urandom_range(0, 1023)));
        write_reg(ofc_pkg::CFG_STOP_DIST, 10'($urandom_range(0, 1023)));
        write_reg(ofc_pkg::CFG_FIRST_STEPS, 10'($urandom_range(0, 1023)));
        write_reg(ofc_pkg::CFG_SWEEP_STEPS, 10'($urandom_range(0, 1023)));
        write_reg(ofc_pkg::CFG_BACK_STEPS, 10'($urandom_range(0, 30)));
        write_reg(ofc_pkg::CFG_SPIN_STEPS, 10'($urandom_range(0, 30)));
      end
    endcase
  endtask

  // Plays one short scene: an approach, a lost object, hovering at a threshold, or noise.
  task automatic play_episode();
    int unsigned pick;
    int unsigned len;
    int          hi;
    int          lo;
    int          thr;
    int          d;
    pick = $urandom_range(99);
    len = $urandom_range(3, 30);
    for (int k = 0; k < len; k++) begin
      if (pick < 30) begin
        hi = int'(follow_start_cm) + 40;
        lo = int'(escape_cm) - 3;
        d = hi - ((hi - lo) * k) / int'(len - 1) + int'($urandom_range(2)) - 1;
      end else if (pick < 60) begin
        d = int'($urandom_range(int'(follow_start_cm) + 1 > 511 ? 511 :
                                int'(follow_start_cm) + 1, 511));
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0: thr = int'(escape_cm);
          1: thr = int'(follow_stop_cm);
          default: thr = int'(follow_start_cm);
        endcase
        d = thr + int'($urandom_range(4)) - 2;
      end else begin
        d = int'($urandom_range(511));
      end
      offer_distance(clamp_cm(d), 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned hold_cycles;
    hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_cycles = HOLD_OFF_CYCLES;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Result checker and cycle counter.
  always @(posedge clk) begin
    ofc_pkg::result_t got;
    ofc_pkg::result_t want;
    cycle_count++;
    if (!rst && in_valid && in_stall) backpressure_cycles++;
    if (!rst && out_valid && !out_stall) begin
      got.left_drive = left_drive;
      got.right_drive = right_drive;
      got.led_color = led_color;
      got.mode_now = mode_now;
      got.finished = finished;
      if (due_commands.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: unexpected command transaction %p", got);
      end else begin
        want = due_commands.pop_front();
        commands_checked++;
        if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
            got.led_color !== want.led_color || got.mode_now !== want.mode_now ||
            got.finished !== want.finished) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"ERROR: command %0d: expected L%0d R%0d led%0d mode%0d fin%0d, ",
                      "got L%0d R%0d led%0d mode%0d fin%0d"},
                     commands_checked, want.left_drive, want.right_drive, want.led_color,
                     want.mode_now, want.finished, got.left_drive, got.right_drive,
                     got.led_color, got.mode_now, got.finished);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("ERROR: timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // Main sequence: reset, directed table, then three idling phases of random scenes.
  initial begin
    int unsigned chunk_start;
    // Directed table, written against the reset settings.
    directed_rows.push_back(typed_row(9'd511, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_OFF, ofc_pkg::MODE_WAIT, 1'b0));
    directed_rows.push_back(typed_row(9'd80, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_GREEN, ofc_pkg::MODE_FOLLOW, 1'b0));
    directed_rows.push_back(typed_row(9'd81, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_RED, ofc_pkg::MODE_SEARCH_R, 1'b0));
    directed_rows.push_back(typed_row(9'd300, ofc_pkg::DRV_FWD, ofc_pkg::DRV_BACK,
                                      ofc_pkg::LED_RED, ofc_pkg::MODE_SEARCH_R, 1'b0));
    directed_rows.push_back(typed_row(9'd70, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_GREEN, ofc_pkg::MODE_FOLLOW, 1'b0));
    directed_rows.push_back(typed_row(9'd31, ofc_pkg::DRV_FWD, ofc_pkg::DRV_FWD,
                                      ofc_pkg::LED_GREEN, ofc_pkg::MODE_FOLLOW, 1'b0));
    directed_rows.push_back(typed_row(9'd30, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_GREEN, ofc_pkg::MODE_FOLLOW, 1'b0));
    directed_rows.push_back(typed_row(9'd21, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_GREEN, ofc_pkg::MODE_FOLLOW, 1'b0));
    directed_rows.push_back(typed_row(9'd20, ofc_pkg::DRV_BACK, ofc_pkg::DRV_BACK,
                                      ofc_pkg::LED_RED, ofc_pkg::MODE_BACK, 1'b0));
    directed_rows.push_back(typed_row(9'd0, ofc_pkg::DRV_BACK, ofc_pkg::DRV_BACK,
                                      ofc_pkg::LED_RED, ofc_pkg::MODE_BACK, 1'b0));
    // A zero back-off length behaves like one, so the next step spins.
    directed_rows.push_back(reg_row(ofc_pkg::CFG_BACK_STEPS, 10'd0));
    directed_rows.push_back(typed_row(9'd511, ofc_pkg::DRV_BACK, ofc_pkg::DRV_FWD,
                                      ofc_pkg::LED_RED, ofc_pkg::MODE_SPIN, 1'b0));
    directed_rows.push_back(reg_row(ofc_pkg::CFG_SPIN_STEPS, 10'd1));
    directed_rows.push_back(typed_row(9'd511, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_OFF, ofc_pkg::MODE_WAIT, 1'b1));
    // A zero first-turn length reverses the search on its first step.
    directed_rows.push_back(reg_row(ofc_pkg::CFG_FIRST_STEPS, 10'd0));
    directed_rows.push_back(typed_row(9'd50, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_GREEN, ofc_pkg::MODE_FOLLOW, 1'b0));
    directed_rows.push_back(typed_row(9'd511, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_RED, ofc_pkg::MODE_SEARCH_R, 1'b0));
    directed_rows.push_back(typed_row(9'd511, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_RED, ofc_pkg::MODE_SEARCH_L, 1'b0));
    directed_rows.push_back(typed_row(9'd511, ofc_pkg::DRV_BACK, ofc_pkg::DRV_FWD,
                                      ofc_pkg::LED_RED, ofc_pkg::MODE_SEARCH_L, 1'b0));
    directed_rows.push_back(typed_row(9'd80, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_GREEN, ofc_pkg::MODE_FOLLOW, 1'b0));
    // Object last seen on the left, so the search now turns left.
    directed_rows.push_back(typed_row(9'd511, ofc_pkg::DRV_STOP, ofc_pkg::DRV_STOP,
                                      ofc_pkg::LED_RED, ofc_pkg::MODE_SEARCH_L, 1'b0));
    directed_rows.push_back(reg_row(CFG_UNUSED_IDX, 10'h3FF));
    directed_rows.push_back(reg_row(ofc_pkg::CFG_ESCAPE_DIST, 10'h3FF));
    directed_rows.push_back(typed_row(9'd511, ofc_pkg::DRV_BACK, ofc_pkg::DRV_BACK,
                                      ofc_pkg::LED_RED, ofc_pkg::MODE_BACK, 1'b0));
    directed_rows.push_back(sample_row(9'd0));
    directed_rows.push_back(sample_row(9'd0));
    directed_rows.push_back(sample_row(9'd255));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG_WRITE) begin
        settle_block();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        offer_distance(directed_rows[i].sample_cm, directed_rows[i].kind == ROW_TYPED,
                       directed_rows[i].want);
      end
    end

    // Random part: receiver-heavy idling, then sender-heavy, then none.
    for (int phase = 0; phase < 3; phase++) begin
      for (int chunk = 0; chunk < 5; chunk++) begin
        settle_block();
        case (phase)
          0: begin
            send_idle_pct = 29;
            recv_idle_pct = 50;
          end
          1: begin
            send_idle_pct = 50;
            recv_idle_pct = 29;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        program_chunk((phase * 5 + chunk) % 5);
        if (phase == 2 && chunk == 1) hold_off_request = 1'b1;
        chunk_start = samples_sent;
        while (samples_sent - chunk_start < CHUNK_ITEMS) play_episode();
      end
    end

    settle_block();
    repeat (10) @(posedge clk);

    $display("Checked %0d commands from %0d distance samples over %0d register writes.",
             commands_checked, samples_sent, reg_writes);
    $display("Escapes completed: %0d, search reversals: %0d, input stall cycles: %0d.",
             escapes_done, search_reversals, backpressure_cycles);
    if (error_count == 0 && due_commands.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (due_commands.size() != 0)
        $display("ERROR: %0d expected commands never arrived", due_commands.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ofc_pkg.sv
rtl/ofc_cfg_regs.sv
rtl/ofc_step.sv
rtl/object_follow_controller.sv
dv/tb_object_follow_controller.sv
